// ===== hdl/http_chunked_body_decoder_unit_assert.svh =====
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define HCBD_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hcbd assertion failed");
`define HCBD_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define HCBD_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_EXT     = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_DATA_CR = 3'd3;
    localparam logic [2:0] PH_DATA_LF = 3'd4;
    localparam logic [2:0] PH_TRAILER = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    localparam logic [1:0] ST_NEED = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data;
        logic [1:0] status;
    } t_result;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hdl/hcbd_core.sv =====
`timescale 1ns / 1ps

module hcbd_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_kind,
    input  logic [7:0]       i_byte,
    output hcbd_pkg::t_result o_result,
    output logic [2:0]       o_phase
);
    import hcbd_pkg::*;

    localparam logic [SIZE_BITS-1:0] CNT_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    logic [2:0]           r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_count, n_count;
    logic                 r_digit, n_digit;
    logic                 r_cr, n_cr;
    logic                 r_line, n_line;
    logic [4:0]           w_hex;
    t_result              w_res;

    assign w_hex = hex_digit(i_byte);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_digit = r_digit;
        n_cr    = r_cr;
        n_line  = r_line;
        w_res.data_valid = 1'b0;
        w_res.data       = 8'h00;
        if (i_kind == KIND_RESTART) begin
            n_phase = PH_SIZE;
            n_count = '0;
            n_digit = 1'b0;
            n_cr    = 1'b0;
            n_line  = 1'b0;
        end else begin
            unique case (r_phase)
                PH_SIZE, PH_EXT: begin
                    if (r_cr && i_byte == CH_LF) begin
                        n_cr = 1'b0;
                        if (!r_digit) begin
                            n_phase = PH_ERROR;
                        end else if (r_count == '0) begin
                            n_line  = 1'b0;
                            n_phase = PH_TRAILER;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (r_phase == PH_EXT) begin
                        n_cr = (i_byte == CH_CR);
                    end else if (r_cr) begin
                        n_phase = PH_ERROR;
                    end else if (i_byte == CH_CR) begin
                        n_cr = 1'b1;
                    end else if (i_byte == CH_SEMI) begin
                        n_phase = r_digit ? PH_EXT : PH_ERROR;
                    end else if (!w_hex[4] || r_count[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_count = {r_count[SIZE_BITS-5:0], w_hex[3:0]};
                        n_digit = 1'b1;
                    end
                end
                PH_DATA: begin
                    w_res.data_valid = 1'b1;
                    w_res.data       = i_byte;
                    n_count          = r_count - CNT_ONE;
                    if (r_count == CNT_ONE) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    n_phase = (i_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
                end
                PH_DATA_LF: begin
                    if (i_byte == CH_LF) begin
                        n_phase = PH_SIZE;
                        n_count = '0;
                        n_digit = 1'b0;
                        n_cr    = 1'b0;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAILER: begin
                    if (r_cr && i_byte == CH_LF) begin
                        n_cr = 1'b0;
                        if (!r_line) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_line = 1'b0;
                        end
                    end else begin
                        if (r_cr || i_byte != CH_CR) begin
                            n_line = 1'b1;
                        end
                        n_cr = (i_byte == CH_CR);
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                PH_ERROR: begin
                    n_phase = PH_ERROR;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
        priority if (n_phase == PH_ERROR) begin
            w_res.status = ST_ERR;
        end else if (n_phase == PH_DONE) begin
            w_res.status = ST_DONE;
        end else begin
            w_res.status = ST_NEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_count <= '0;
            r_digit <= 1'b0;
            r_cr    <= 1'b0;
            r_line  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_digit <= n_digit;
            r_cr    <= n_cr;
            r_line  <= n_line;
        end
    end

    assign o_result = w_res;
    assign o_phase  = r_phase;

endmodule

// ===== hdl/http_chunked_body_decoder_unit.sv =====
// An accepted input beat passes through the input register and then the result register to the output.
// Throughput: one beat per cycle while the output is not stalled; the parser state updates once per beat.
// An input register and a result register part the two sides.
// Reset (synchronous, active low) empties both registers and rearms the
// parser at the start of a size line.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_unit_assert.svh"

module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_data_valid,
    output logic [7:0] o_data_out,
    output logic [1:0] o_status
);
    import hcbd_pkg::*;

    logic       r_s1_valid, n_s1_valid;
    logic       r_s1_kind;
    logic [7:0] r_s1_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic [2:0] w_phase;
    logic       w_out_free;
    logic       w_adv;
    logic       w_in_acc;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    hcbd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_kind  (r_s1_kind),
        .i_byte  (r_s1_byte),
        .o_result(w_res),
        .o_phase (w_phase)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_acc) begin
            n_s1_valid = 1'b1;
        end else if (w_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_kind <= i_kind;
            r_s1_byte <= i_byte_in;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_valid = r_out.data_valid;
    assign o_data_out   = r_out.data;
    assign o_status     = r_out.status;

    `HCBD_ASSERT_NXT(a_err_sticky, i_clk, i_rst_n, w_phase == PH_ERROR && !(w_adv && r_s1_kind == KIND_RESTART), w_phase == PH_ERROR)
    `HCBD_ASSERT_NXT(a_done_sticky, i_clk, i_rst_n, w_phase == PH_DONE && !(w_adv && r_s1_kind == KIND_RESTART), w_phase == PH_DONE)
    `HCBD_ASSERT_NXT(a_adv_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `HCBD_ASSERT_IMP(a_data_need, i_clk, i_rst_n, r_out_valid && o_data_valid, o_status == ST_NEED)

endmodule

// ===== sim/http_chunked_body_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit_test;
    import hcbd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int BEATS_PER_PHASE = 585;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
    } t_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_kind;
    logic [7:0] i_byte_in;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_data_valid;
    logic [7:0] o_data_out;
    logic [1:0] o_status;

    t_beat      pending[$];
    t_result    expected[$];
    logic [7:0] msg[$];

    logic [2:0]  dec_phase;
    logic [63:0] dec_count;
    logic        dec_digit;
    logic        dec_cr;
    logic        dec_line;

    int   send_idle;
    int   recv_idle;
    logic in_took;
    logic hold_go;
    logic hold_done;
    int   hold_left;
    int   mismatches;
    int   quiet_cycles;

    http_chunked_body_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_byte_in   (i_byte_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_valid(o_data_valid),
        .o_data_out  (o_data_out),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_decoder();
        dec_phase = PH_SIZE;
        dec_count = '0;
        dec_digit = 1'b0;
        dec_cr    = 1'b0;
        dec_line  = 1'b0;
    endfunction

    function automatic void close_size_line();
        dec_cr = 1'b0;
        if (!dec_digit) begin
            dec_phase = PH_ERROR;
        end else if (dec_count == 0) begin
            dec_line  = 1'b0;
            dec_phase = PH_TRAILER;
        end else begin
            dec_phase = PH_DATA;
        end
    endfunction

    function automatic t_result decode_beat(input t_beat bt);
        t_result    r;
        logic [7:0] b;
        logic       is_hex;
        logic [3:0] nib;
        r      = '0;
        b      = bt.byte_in;
        is_hex = 1'b1;
        nib    = '0;
        if (bt.kind == KIND_RESTART) begin
            clear_decoder();
        end else begin
            case (dec_phase)
                PH_SIZE: begin
                    if (dec_cr) begin
                        if (b == CH_LF) close_size_line();
                        else dec_phase = PH_ERROR;
                    end else if (b == CH_CR) begin
                        dec_cr = 1'b1;
                    end else if (b == CH_SEMI) begin
                        dec_phase = dec_digit ? PH_EXT : PH_ERROR;
                    end else begin
                        if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
                        else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h61 + 8'd10);
                        else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h41 + 8'd10);
                        else is_hex = 1'b0;
                        if (!is_hex || (dec_count >> (SIZE_BITS_DEF - 4)) != 0) begin
                            dec_phase = PH_ERROR;
                        end else begin
                            dec_count = {dec_count[59:0], nib};
                            dec_digit = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    if (dec_cr && b == CH_LF) close_size_line();
                    else dec_cr = (b == CH_CR);
                end
                PH_DATA: begin
                    r.data_valid = 1'b1;
                    r.data       = b;
                    dec_count    = dec_count - 1;
                    if (dec_count == 0) dec_phase = PH_DATA_CR;
                end
                PH_DATA_CR: begin
                    dec_phase = (b == CH_CR) ? PH_DATA_LF : PH_ERROR;
                end
                PH_DATA_LF: begin
                    if (b == CH_LF) begin
                        dec_phase = PH_SIZE;
                        dec_count = '0;
                        dec_digit = 1'b0;
                        dec_cr    = 1'b0;
                    end else begin
                        dec_phase = PH_ERROR;
                    end
                end
                PH_TRAILER: begin
                    if (dec_cr && b == CH_LF) begin
                        dec_cr = 1'b0;
                        if (!dec_line) dec_phase = PH_DONE;
                        else dec_line = 1'b0;
                    end else begin
                        if (dec_cr || b != CH_CR) dec_line = 1'b1;
                        dec_cr = (b == CH_CR);
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    dec_phase = PH_ERROR;
                end
            endcase
        end
        if (dec_phase == PH_ERROR) r.status = ST_ERR;
        else if (dec_phase == PH_DONE) r.status = ST_DONE;
        else r.status = ST_NEED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic add_beat(input logic kind, input logic [7:0] b);
        t_beat bt;
        bt.kind    = kind;
        bt.byte_in = b;
        pending.push_back(bt);
    endtask

    task automatic flush_msg();
        foreach (msg[k]) add_beat(KIND_BYTE, msg[k]);
        msg.delete();
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) msg.push_back(s[k]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 10) return 8'h30 + d;
        if ($urandom_range(1)) return 8'h61 + d - 8'd10;
        return 8'h41 + d - 8'd10;
    endfunction

    task automatic add_size(input int unsigned value, input int zeros);
        logic [7:0]  digits[$];
        int unsigned v;
        v = value;
        repeat (zeros) msg.push_back(8'h30);
        do begin
            digits.push_front(hex_char(v[3:0]));
            v = v >> 4;
        end while (v != 0);
        foreach (digits[k]) msg.push_back(digits[k]);
    endtask

    // line content without CRLF; a lone CR is followed by a non-LF byte
    task automatic add_junk(input int n);
        logic [7:0] b;
        repeat (n) begin
            if ($urandom_range(99) < 15) begin
                msg.push_back(CH_CR);
                b = 8'h78;
            end else begin
                do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
            end
            msg.push_back(b);
        end
    endtask

    task automatic build_message();
        int size;
        repeat ($urandom_range(3)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            add_size(size, ($urandom_range(4) == 0) ? $urandom_range(1, 9) : 0);
            if ($urandom_range(3) == 0) begin
                msg.push_back(CH_SEMI);
                add_junk($urandom_range(6));
            end
            add_text("\r\n");
            repeat (size) msg.push_back(8'($urandom_range(255)));
            add_text("\r\n");
        end
        add_size(0, $urandom_range(2));
        if ($urandom_range(3) == 0) begin
            msg.push_back(CH_SEMI);
            add_junk($urandom_range(4));
        end
        add_text("\r\n");
        repeat ($urandom_range(2)) begin
            add_junk($urandom_range(1, 8));
            add_text("\r\n");
        end
        add_text("\r\n");
    endtask

    task automatic add_random_traffic(input int count);
        int stop;
        int pick;
        int idx;
        stop = pending.size() + count;
        while (pending.size() < stop) begin
            pick = $urandom_range(99);
            msg.delete();
            if (pick < 75) begin
                build_message();
                if ($urandom_range(9) < 3) begin
                    repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
                end
            end else if (pick < 82) begin
                repeat ($urandom_range(2)) msg.push_back(8'h30);
                msg.push_back(hex_char(4'($urandom_range(1, 15))));
                if ($urandom_range(1)) begin
                    repeat (7) msg.push_back(hex_char(4'($urandom_range(15))));
                    add_text("\r\n");
                end else begin
                    repeat ($urandom_range(8, 10)) msg.push_back(hex_char(4'($urandom_range(15))));
                end
                repeat ($urandom_range(6)) msg.push_back(8'($urandom_range(255)));
            end else if (pick < 92) begin
                build_message();
                if ($urandom_range(1)) begin
                    idx = $urandom_range(msg.size() - 1);
                    while (msg.size() > idx) void'(msg.pop_back());
                end else begin
                    idx = $urandom_range(msg.size() - 1);
                    if ($urandom_range(1)) begin
                        while (idx < msg.size() - 1 && msg[idx] != CH_CR && msg[idx] != CH_LF)
                            idx++;
                    end
                    msg[idx] = 8'($urandom_range(255));
                end
            end else begin
                repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom_range(255)));
            end
            if (pick < 92 || $urandom_range(1)) add_beat(KIND_RESTART, 8'($urandom_range(255)));
            flush_msg();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_beat   bt;
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected.size() == 0) begin
                    report_mismatch("unexpected beat, status", o_status, 0);
                end else begin
                    want = expected.pop_front();
                    if (o_data_valid !== want.data_valid)
                        report_mismatch("data_valid", o_data_valid, want.data_valid);
                    if (o_data_out !== want.data)
                        report_mismatch("data_out", o_data_out, want.data);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                bt.kind    = i_kind;
                bt.byte_in = i_byte_in;
                expected.push_back(decode_beat(bt));
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(negedge i_clk) begin
        t_beat bt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                bt = pending.pop_front();
                i_in_valid <= 1'b1;
                i_kind     <= bt.kind;
                i_byte_in  <= bt.byte_in;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    task automatic wait_sent();
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_BYTE;
        i_byte_in    = 8'h00;
        i_out_stall  = 1'b0;
        in_took      = 1'b0;
        hold_go      = 1'b0;
        hold_done    = 1'b0;
        hold_left    = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        send_idle    = 31;
        recv_idle    = 86;
        clear_decoder();

        add_beat(KIND_RESTART, 8'hFF);
        add_text(";x");
        flush_msg();
        add_beat(KIND_RESTART, 8'h00);
        add_text("G");
        flush_msg();
        add_beat(KIND_RESTART, 8'($urandom_range(255)));
        add_text("\r\r");
        flush_msg();
        add_beat(KIND_RESTART, 8'($urandom_range(255)));
        add_text("1;\rz\r\n");
        msg.push_back(8'hFF);
        add_text("\r\n0\r\nh\r\n\r\n.");
        flush_msg();
        add_random_traffic(BEATS_PER_PHASE - pending.size());

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_sent();
        send_idle = 86;
        recv_idle = 31;
        add_random_traffic(BEATS_PER_PHASE);

        wait_sent();
        send_idle = 0;
        recv_idle = 0;
        hold_go   = 1'b1;
        add_random_traffic(BEATS_PER_PHASE);

        while (pending.size() != 0 || i_in_valid || expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_core.sv
hdl/http_chunked_body_decoder_unit.sv
sim/http_chunked_body_decoder_unit_test.sv
